>>> sv/pida_pkg.sv
// ----------------------------------------------------------------------------
// pida_pkg
// Shared types and constants for the positional insert/delete array block:
// field widths, operation and status codes, controller/datapath handshakes.
// ----------------------------------------------------------------------------
package pida_pkg;

  localparam int FUNC_W = 2;
  localparam int DATA_W = 32;
  localparam int POS_W  = 7;
  localparam int STAT_W = 2;
  localparam int MEAN_W = 40;
  localparam int LEN_W  = 7;
  localparam int FRAC_W = 8;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_INSERT  = 2'd0,
    FUNC_DELETE  = 2'd1,
    FUNC_AVERAGE = 2'd2,
    FUNC_DISPLAY = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic    ld_val;      // capture the insert value
    logic    rd_en;       // memory read, data registered
    logic    wr_en;       // memory write
    logic    wr_sel_val;  // write captured value instead of read data
    logic    acc_clr;     // clear sum
    logic    acc_en;      // add read data to sum
    logic    div_start;   // launch the divider
    logic    emit;        // load the output register
    status_t emit_status;
    logic    emit_last;
    logic    emit_elem;   // element field from read data
    logic    emit_mean;   // mean field from divider
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;  // output register can take a transaction this cycle
    logic div_done;  // quotient ready
  } dp_stat_t;

endpackage

>>> sv/pida_if.sv
// ----------------------------------------------------------------------------
// pida_if
// Valid/ready channel interfaces for operation requests and results.
// ----------------------------------------------------------------------------
interface pida_in_if import pida_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [DATA_W-1:0] value;
  logic [POS_W-1:0]         position;

  modport source (output valid, output func, output value, output position, input ready);
  modport sink   (input valid, input func, input value, input position, output ready);
endinterface

interface pida_out_if import pida_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic signed [DATA_W-1:0] element;
  logic signed [MEAN_W-1:0] mean;
  logic [LEN_W-1:0]         length;
  logic                     last;

  modport source (output valid, output status, output element, output mean,
                  output length, output last, input ready);
  modport sink   (input valid, input status, input element, input mean,
                  input length, input last, output ready);
endinterface

>>> sv/pida_div.sv
// ----------------------------------------------------------------------------
// pida_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pida_div import pida_pkg::*; #(
  parameter int DW = 47,
  parameter int VW = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic [DW-1:0] quotient,
  output logic          done
);

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    quo_r;
  logic [VW-1:0]    rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;
  logic [VW:0]      rem_sh;
  logic [VW:0]      diff;
  logic             ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh = {rem_r, quo_r[DW-1]};
    diff   = rem_sh - {1'b0, divisor};
    ge     = (rem_sh >= {1'b0, divisor});
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      cnt_r <= CNT_W'(DW);
    end else if (busy_r) begin
      quo_r <= {quo_r[DW-2:0], ge};
      rem_r <= ge ? diff[VW-1:0] : rem_sh[VW-1:0];
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  // busy and done flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && (cnt_r == CNT_W'(1))) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

`ifndef SYNTHESIS
  a_start_clears_done: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !done_r) else $error("divider done right after start");
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("divider done while still iterating");
`endif

endmodule

>>> sv/pida_dpath.sv
// ----------------------------------------------------------------------------
// pida_dpath
// Element store, running sum, divider for the mean and the output register.
// ----------------------------------------------------------------------------
module pida_dpath import pida_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  input  logic [AW-1:0]            rd_addr,
  input  logic [AW-1:0]            wr_addr,
  input  logic [CW-1:0]            count,
  input  logic [LEN_W-1:0]         emit_len,
  input  logic signed [DATA_W-1:0] in_value,
  output dp_stat_t                 stat,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STAT_W-1:0]        out_status,
  output logic signed [DATA_W-1:0] out_element,
  output logic signed [MEAN_W-1:0] out_mean,
  output logic [LEN_W-1:0]         out_length,
  output logic                     out_last
);

  localparam int SUM_W  = DATA_W + CW;
  localparam int PROD_W = SUM_W + FRAC_W;

  logic [DATA_W-1:0]        mem_r [DEPTH];
  logic signed [DATA_W-1:0] rdata_r;
  logic signed [DATA_W-1:0] value_r;
  logic signed [SUM_W-1:0]  acc_r;
  logic [SUM_W-1:0]         acc_mag;
  logic [PROD_W-1:0]        dividend;
  logic [PROD_W-1:0]        quo;
  logic [PROD_W-1:0]        mean_full;
  logic                     div_done;
  logic [DATA_W-1:0]        wr_data;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  status_t                  out_status_r;
  logic signed [DATA_W-1:0] out_element_r;
  logic signed [MEAN_W-1:0] out_mean_r;
  logic [LEN_W-1:0]         out_length_r;
  logic                     out_last_r;

  // element store, one write and one registered read per cycle
  assign wr_data = cmd.wr_sel_val ? value_r : rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  // captured insert value and running sum
  always_ff @(posedge clk) begin
    if (cmd.ld_val) begin
      value_r <= in_value;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (cmd.acc_en) begin
      acc_r <= acc_r + SUM_W'(rdata_r);
    end
  end

  // magnitude of sum scaled by the fraction bits, sign restored afterwards
  assign acc_mag   = acc_r[SUM_W-1] ? SUM_W'(-acc_r) : SUM_W'(acc_r);
  assign dividend  = {acc_mag, {FRAC_W{1'b0}}};
  assign mean_full = acc_r[SUM_W-1] ? (~quo + PROD_W'(1)) : quo;

  pida_div #(
    .DW (PROD_W),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (count),
    .quotient (quo),
    .done     (div_done)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r  <= cmd.emit_status;
      out_element_r <= cmd.emit_elem ? rdata_r : '0;
      out_mean_r    <= cmd.emit_mean ? signed'(mean_full[MEAN_W-1:0]) : '0;
      out_length_r  <= emit_len;
      out_last_r    <= cmd.emit_last;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign stat.div_done = div_done;

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_mean    = out_mean_r;
  assign out_length  = out_length_r;
  assign out_last    = out_last_r;

endmodule

>>> sv/pida_ctrl.sv
// ----------------------------------------------------------------------------
// pida_ctrl
// Operation sequencer: position checks, element shifting, sum walk,
// display walk and result issue. Owns the list length.
// ----------------------------------------------------------------------------
module pida_ctrl import pida_pkg::*; #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [FUNC_W-1:0]  in_func,
  input  logic [POS_W-1:0]   in_position,
  input  dp_stat_t           stat,
  output dp_cmd_t            cmd,
  output logic [AW-1:0]      rd_addr,
  output logic [AW-1:0]      wr_addr,
  output logic [CW-1:0]      count,
  output logic [LEN_W-1:0]   emit_len
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_UP   = 9'b000000010,
    S_INS  = 9'b000000100,
    S_DOWN = 9'b000001000,
    S_SUM  = 9'b000010000,
    S_DIV  = 9'b000100000,
    S_DRD  = 9'b001000000,
    S_DLD  = 9'b010000000,
    S_EMIT = 9'b100000000
  } state_t;

  state_t        state_r,     state_nxt;
  logic [CW-1:0] count_r,     count_nxt;
  logic [CW-1:0] idx_r,       idx_nxt;
  logic [CW-1:0] pos_r,       pos_nxt;
  logic          pend_r,      pend_nxt;
  logic [AW-1:0] pend_addr_r, pend_addr_nxt;
  status_t       status_r,    status_nxt;
  logic          mean_sel_r,  mean_sel_nxt;

  logic [CW-1:0]    idx_dec;
  logic [CW-1:0]    idx_inc;
  logic [LEN_W-1:0] count_ext;
  logic             accept;

  assign idx_dec   = idx_r - CW'(1);
  assign idx_inc   = idx_r + CW'(1);
  assign count_ext = LEN_W'(count_r);
  assign in_ready  = (state_r == S_IDLE) && rst_n;
  assign accept    = in_valid && in_ready;

  // next state and command decode
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    status_nxt    = status_r;
    mean_sel_nxt  = mean_sel_r;
    cmd           = '0;
    rd_addr       = '0;
    wr_addr       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.ld_val   = 1'b1;
          mean_sel_nxt = 1'b0;
          pend_nxt     = 1'b0;
          unique case (func_t'(in_func))
            FUNC_INSERT: begin
              if (in_position > count_ext) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_EMIT;
              end else if (count_r == CW'(DEPTH)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_EMIT;
              end else begin
                pos_nxt   = CW'(in_position);
                idx_nxt   = count_r;
                state_nxt = S_UP;
              end
            end
            FUNC_DELETE: begin
              if (in_position >= count_ext) begin
                status_nxt = ST_BADPOS;
                state_nxt  = S_EMIT;
              end else begin
                idx_nxt   = CW'(in_position) + CW'(1);
                state_nxt = S_DOWN;
              end
            end
            FUNC_AVERAGE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_EMIT;
              end else begin
                cmd.acc_clr = 1'b1;
                idx_nxt     = '0;
                state_nxt   = S_SUM;
              end
            end
            FUNC_DISPLAY: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt  = S_EMIT;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_DRD;
              end
            end
          endcase
        end
      end

      // move entries up from the tail down to the insert position
      S_UP: begin
        if (pend_r) begin
          cmd.wr_en = 1'b1;
          wr_addr   = pend_addr_r;
        end
        if (idx_r > pos_r) begin
          cmd.rd_en     = 1'b1;
          rd_addr       = idx_dec[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r[AW-1:0];
          idx_nxt       = idx_dec;
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_INS;
        end
      end

      S_INS: begin
        cmd.wr_en      = 1'b1;
        cmd.wr_sel_val = 1'b1;
        wr_addr        = pos_r[AW-1:0];
        count_nxt      = count_r + CW'(1);
        status_nxt     = ST_OK;
        state_nxt      = S_EMIT;
      end

      // move entries down over the deleted slot
      S_DOWN: begin
        if (pend_r) begin
          cmd.wr_en = 1'b1;
          wr_addr   = pend_addr_r;
        end
        if (idx_r < count_r) begin
          cmd.rd_en     = 1'b1;
          rd_addr       = idx_r[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_dec[AW-1:0];
          idx_nxt       = idx_inc;
        end else begin
          pend_nxt   = 1'b0;
          count_nxt  = count_r - CW'(1);
          status_nxt = ST_OK;
          state_nxt  = S_EMIT;
        end
      end

      // walk the list into the sum, then launch the divide
      S_SUM: begin
        if (pend_r) begin
          cmd.acc_en = 1'b1;
        end
        if (idx_r < count_r) begin
          cmd.rd_en = 1'b1;
          rd_addr   = idx_r[AW-1:0];
          pend_nxt  = 1'b1;
          idx_nxt   = idx_inc;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
        end
      end

      S_DIV: begin
        if (stat.div_done) begin
          status_nxt   = ST_OK;
          mean_sel_nxt = 1'b1;
          state_nxt    = S_EMIT;
        end
      end

      // display: fetch one element, then hand it out
      S_DRD: begin
        cmd.rd_en = 1'b1;
        rd_addr   = idx_r[AW-1:0];
        state_nxt = S_DLD;
      end

      S_DLD: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_elem   = 1'b1;
          cmd.emit_status = ST_OK;
          cmd.emit_last   = (idx_inc == count_r);
          idx_nxt         = idx_inc;
          state_nxt       = (idx_inc == count_r) ? S_IDLE : S_DRD;
        end
      end

      // single result transaction
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = status_r;
          cmd.emit_last   = 1'b1;
          cmd.emit_mean   = mean_sel_r;
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    pos_r       <= pos_nxt;
    pend_addr_r <= pend_addr_nxt;
    status_r    <= status_nxt;
    mean_sel_r  <= mean_sel_nxt;
  end

  assign count    = count_r;
  assign emit_len = count_ext;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH)) else $error("list length beyond store depth");
  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free) else $error("result issued into a busy output");
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE)) else $error("accepted transaction not started");
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_en && cmd.rd_en) |-> (wr_addr != rd_addr))
    else $error("shift reads and writes the same entry");
`endif

endmodule

>>> sv/positional_insert_delete_array.sv
// ----------------------------------------------------------------------------
// positional_insert_delete_array
// Insert: shifts entries from the tail down to the position up, then writes the value.
// Delete: shifts entries above the position down over it. Average: walks the list
//   into the sum, then runs the serial divider on a 47-bit dividend at depth 64.
// Display: one memory read per element; one transaction at a time.
// Reset (rst_n low, synchronous) empties the list; store contents are kept.
// ----------------------------------------------------------------------------
module positional_insert_delete_array import pida_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  pida_in_if.sink     in_ch,
  pida_out_if.source  out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [CW-1:0]    count;
  logic [LEN_W-1:0] emit_len;

  // sequencer
  pida_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_func     (in_ch.func),
    .in_position (in_ch.position),
    .stat        (stat),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .count       (count),
    .emit_len    (emit_len)
  );

  // store, arithmetic and output stage
  pida_dpath #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr),
    .count       (count),
    .emit_len    (emit_len),
    .in_value    (in_ch.value),
    .stat        (stat),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_status  (out_ch.status),
    .out_element (out_ch.element),
    .out_mean    (out_ch.mean),
    .out_length  (out_ch.length),
    .out_last    (out_ch.last)
  );

endmodule
